// ===== sv/text_cell_glyph_renderer_assert.svh =====
// Assertion shorthands for the glyph renderer checker.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CELL_GLYPH_RENDERER_ASSERT_SVH

// Same-cycle implication
`define TCGR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TCGR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tcgr_pkg.sv =====
package tcgr_pkg;

    localparam int GLYPH_WIDTH = 8;
    localparam int PIX_W       = 24;
    localparam int LADDR_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Input action codes
    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_WIDTH  = 3'd1,
        CFG_HEIGHT = 3'd2,
        CFG_PITCH  = 3'd3,
        CFG_BPP    = 3'd4
    } cfg_idx_t;

    // Fixed 16-color palette
    localparam logic [PIX_W-1:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct packed {
        logic        enable;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [15:0] line_pitch;
        logic [2:0]  bytes_per_pixel;
    } cfg_t;

    // Travels alongside a font read, lined up with the read data
    typedef struct packed {
        logic               valid;
        logic [LADDR_W-1:0] line_address;
        logic [3:0]         fg_idx;
        logic [3:0]         bg_idx;
        logic               last;
        logic               blank;
    } rd_meta_t;

    typedef struct packed {
        logic [LADDR_W-1:0]                  line_address;
        logic [GLYPH_WIDTH-1:0][PIX_W-1:0]   pix;
        logic                                last;
    } out_ent_t;

endpackage

// ===== sv/tcgr_font_ram.sv =====
module tcgr_font_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tcgr_seq.sv =====
module tcgr_seq #(
    parameter int          GLYPH_HEIGHT = 16,
    parameter int          GLYPH_COUNT  = 256,
    parameter logic [31:0] FRAME_BASE   = 32'hFF00_0000,
    parameter int          AW           = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcgr_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [7:0]          char_code,
    input  logic [7:0]          attribute,
    input  logic [8:0]          cell_column,
    input  logic [7:0]          cell_row,
    input  logic [3:0]          glyph_line,
    input  logic [7:0]          glyph_bits,
    input  logic                pop,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    output tcgr_pkg::rd_meta_t  meta
);
    import tcgr_pkg::*;

    localparam int LW       = $clog2(GLYPH_HEIGHT);
    localparam int ROW_PX_W = $clog2(256 * GLYPH_HEIGHT);
    localparam logic [LW-1:0] LINE_LAST = LW'(GLYPH_HEIGHT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } state_t;

    state_t                state_reg;
    logic [1:0]            cnt_reg;
    logic [LW-1:0]         line_reg;
    logic [AW-1:0]         code_base_reg;
    logic                  blank_reg;
    logic [3:0]            fg_reg;
    logic [3:0]            bg_reg;
    logic [ROW_PX_W-1:0]   row_px_reg;
    logic [14:0]           xoff_reg;
    logic [LADDR_W-1:0]    addr_reg;
    logic                  meta_vld_reg;
    logic [LADDR_W-1:0]    meta_addr_reg;
    logic [3:0]            meta_fg_reg;
    logic [3:0]            meta_bg_reg;
    logic                  meta_last_reg;
    logic                  meta_blank_reg;

    logic          accept;
    logic [AW-1:0] code_base;
    logic          load_ok;
    logic          col_fit;
    logic          row_fit;
    logic          draw_ok;
    logic          issue;

    // Intake: one transaction at a time, taken only when idle
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign code_base = AW'(32'(char_code) * GLYPH_HEIGHT);
    assign load_ok   = (32'(glyph_line) < GLYPH_HEIGHT) && (32'(char_code) < GLYPH_COUNT);

    // Cell fits when its far edge stays within the screen (no divide needed)
    assign col_fit = ((32'(cell_column) + 32'd1) * GLYPH_WIDTH) <= 32'(cfg.screen_width);
    assign row_fit = ((32'(cell_row) + 32'd1) * GLYPH_HEIGHT) <= 32'(cfg.screen_height);
    assign draw_ok = cfg.enable && col_fit && row_fit;

    // Font writes happen only in idle, reads only in run: no same-entry overlap
    assign wr_en   = accept && (action == ACT_LOAD) && load_ok;
    assign wr_addr = code_base + AW'(glyph_line);
    assign wr_data = glyph_bits;

    // Issue a line read while the output queue has a free slot
    assign issue   = (state_reg == S_RUN) && ((cnt_reg < 2'd2) || pop);
    assign rd_en   = issue;
    assign rd_addr = code_base_reg + AW'(line_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= 2'd0;
            meta_vld_reg <= 1'b0;
        end
        else
        begin
            // lines issued and not yet taken downstream
            cnt_reg      <= cnt_reg + 2'(issue) - 2'(pop);
            meta_vld_reg <= issue;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (action == ACT_DRAW) && draw_ok)
                    begin
                        code_base_reg <= code_base;
                        blank_reg     <= !(32'(char_code) < GLYPH_COUNT);
                        fg_reg        <= attribute[3:0];
                        bg_reg        <= attribute[7:4];
                        row_px_reg    <= ROW_PX_W'(32'(cell_row) * GLYPH_HEIGHT);
                        xoff_reg      <= 15'(15'({cell_column, 3'b000})
                                             * 15'(cfg.bytes_per_pixel));
                        line_reg      <= '0;
                        state_reg     <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    // start address of the cell's top line
                    addr_reg  <= FRAME_BASE
                                 + 32'(32'(row_px_reg) * 32'(cfg.line_pitch))
                                 + 32'(xoff_reg);
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (issue)
                    begin
                        meta_addr_reg  <= addr_reg;
                        meta_fg_reg    <= fg_reg;
                        meta_bg_reg    <= bg_reg;
                        meta_last_reg  <= (line_reg == LINE_LAST);
                        meta_blank_reg <= blank_reg;
                        addr_reg       <= addr_reg + 32'(cfg.line_pitch);
                        line_reg       <= line_reg + LW'(1);
                        if (line_reg == LINE_LAST)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign meta = '{valid:        meta_vld_reg,
                    line_address: meta_addr_reg,
                    fg_idx:       meta_fg_reg,
                    bg_idx:       meta_bg_reg,
                    last:         meta_last_reg,
                    blank:        meta_blank_reg};

endmodule

// ===== sv/tcgr_out.sv =====
module tcgr_out (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  tcgr_pkg::rd_meta_t                           meta,
    input  logic [7:0]                                   rd_data,
    input  logic                                         out_stall,
    output logic                                         out_valid,
    output logic                                         pop,
    output logic [tcgr_pkg::LADDR_W-1:0]                 line_address,
    output logic [tcgr_pkg::GLYPH_WIDTH-1:0][tcgr_pkg::PIX_W-1:0] pix,
    output logic                                         last_line
);
    import tcgr_pkg::*;

    logic [1:0] cnt_reg;
    out_ent_t   head_reg;
    out_ent_t   tail_reg;

    logic       push;
    out_ent_t   ent;
    logic [7:0] bits;
    logic [PIX_W-1:0] fg;
    logic [PIX_W-1:0] bg;

    // Expand the glyph row into palette colors, leftmost bit first
    assign bits = meta.blank ? 8'h00 : rd_data;
    assign fg   = PALETTE[meta.fg_idx];
    assign bg   = PALETTE[meta.bg_idx];

    always_comb
    begin
        ent.line_address = meta.line_address;
        ent.last         = meta.last;
        for (int p = 0; p < GLYPH_WIDTH; p++)
        begin
            ent.pix[p] = bits[GLYPH_WIDTH-1-p] ? fg : bg;
        end
    end

    assign push      = meta.valid;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    // Two-entry queue; the head drives the ports
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (push && pop)
            begin
                if (cnt_reg == 2'd1)
                begin
                    head_reg <= ent;
                end
                else
                begin
                    head_reg <= tail_reg;
                    tail_reg <= ent;
                end
            end
            else if (push)
            begin
                if (cnt_reg == 2'd0)
                begin
                    head_reg <= ent;
                end
                else
                begin
                    tail_reg <= ent;
                end
            end
            else if (pop)
            begin
                head_reg <= tail_reg;
            end
        end
    end

    assign line_address = head_reg.line_address;
    assign pix          = head_reg.pix;
    assign last_line    = head_reg.last;

endmodule

// ===== sv/text_cell_glyph_renderer.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | action, char_code, attribute, cell_column,
//         |           |                      | cell_row, glyph_line, glyph_bits
// out     | output    | out_valid / out_stall| line_address, pixel_0..pixel_7, last_line
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A load is written to the font RAM in the cycle it is taken. A draw holds the input
// through S_SETUP (address setup), then one read per glyph line (single read port).
// Each line passes the RAM read register and the output queue; lines follow one per cycle
// while out_stall is low; it pauses reads via the two-entry queue; nothing is dropped.
// Reset (rst_n, async low) restores register defaults; font contents stay undefined.
module text_cell_glyph_renderer #(
    parameter int          GLYPH_HEIGHT = 16,
    parameter int          GLYPH_COUNT  = 256,
    parameter logic [31:0] FRAME_BASE   = 32'hFF00_0000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [7:0]                        char_code,
    input  logic [7:0]                        attribute,
    input  logic [8:0]                        cell_column,
    input  logic [7:0]                        cell_row,
    input  logic [3:0]                        glyph_line,
    input  logic [7:0]                        glyph_bits,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [31:0]                       line_address,
    output logic [23:0]                       pixel_0,
    output logic [23:0]                       pixel_1,
    output logic [23:0]                       pixel_2,
    output logic [23:0]                       pixel_3,
    output logic [23:0]                       pixel_4,
    output logic [23:0]                       pixel_5,
    output logic [23:0]                       pixel_6,
    output logic [23:0]                       pixel_7,
    output logic                              last_line
);
    import tcgr_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    cfg_t     cfg_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    rd_meta_t      meta;
    logic          pop;
    logic [GLYPH_WIDTH-1:0][PIX_W-1:0] pix;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= 1'b0;
            cfg_reg.screen_width    <= 12'd640;
            cfg_reg.screen_height   <= 12'd480;
            cfg_reg.line_pitch      <= 16'd2560;
            cfg_reg.bytes_per_pixel <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE: cfg_reg.enable          <= cfg_data[0];
                CFG_WIDTH:  cfg_reg.screen_width    <= cfg_data[11:0];
                CFG_HEIGHT: cfg_reg.screen_height   <= cfg_data[11:0];
                CFG_PITCH:  cfg_reg.line_pitch      <= cfg_data;
                CFG_BPP:    cfg_reg.bytes_per_pixel <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    tcgr_seq #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_COUNT  (GLYPH_COUNT),
        .FRAME_BASE   (FRAME_BASE),
        .AW           (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .char_code   (char_code),
        .attribute   (attribute),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .glyph_line  (glyph_line),
        .glyph_bits  (glyph_bits),
        .pop         (pop),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .meta        (meta)
    );

    tcgr_font_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcgr_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .meta         (meta),
        .rd_data      (rd_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pop          (pop),
        .line_address (line_address),
        .pix          (pix),
        .last_line    (last_line)
    );

    assign pixel_0 = pix[0];
    assign pixel_1 = pix[1];
    assign pixel_2 = pix[2];
    assign pixel_3 = pix[3];
    assign pixel_4 = pix[4];
    assign pixel_5 = pix[5];
    assign pixel_6 = pix[6];
    assign pixel_7 = pix[7];

endmodule

// ===== sv/tcgr_checker.sv =====
`include "text_cell_glyph_renderer_assert.svh"

module tcgr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] line_address,
    input  logic        last_line
);

    logic [32:0] out_word;
    logic        out_held;
    logic        out_take;

    assign out_word = {line_address, last_line};
    assign out_held = out_valid && out_stall;
    assign out_take = out_valid && !out_stall;

    // A stalled line transaction holds
    `TCGR_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled line changed")

    // Lines of one cell come back to back once the output is taken
    `TCGR_ASSERT_NEXT(a_cell_no_gap, out_take && !last_line, out_valid, "gap inside a cell")

    // An offered line carries known address and flag
    `TCGR_ASSERT_NOW(a_out_known, out_valid, !$isunknown(out_word), "unknown line transaction")

endmodule

bind text_cell_glyph_renderer tcgr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_address (line_address),
    .last_line    (last_line)
);

// ===== tb/text_cell_glyph_renderer_test.sv =====
// One glyph line as seen on the output channel
typedef struct packed {
    logic [31:0]      addr;
    logic [7:0][23:0] pix;
    logic             last;
} glyph_line_t;

// One input transaction
typedef struct packed {
    bit       action;
    bit [7:0] code;
    bit [7:0] attr;
    bit [8:0] col;
    bit [7:0] row;
    bit [3:0] gline;
    bit [7:0] gbits;
} cell_req_t;

// Keeps a private copy of the font and registers, predicts glyph lines
class render_checker;
    localparam bit [31:0] FRAME_BASE = 32'hFF00_0000;

    bit [7:0]    font_rows [256][16];
    bit          enable;
    bit [11:0]   width;
    bit [11:0]   height;
    bit [15:0]   pitch;
    bit [2:0]    bpp;
    glyph_line_t expected_lines[$];
    int unsigned mismatches;
    int unsigned lines_checked;

    function new();
        enable        = 1'b0;
        width         = 12'd640;
        height        = 12'd480;
        pitch         = 16'd2560;
        bpp           = 3'd4;
        mismatches    = 0;
        lines_checked = 0;
    endfunction

    // Standard 16-color text palette
    function bit [23:0] color_of(bit [3:0] idx);
        case (idx)
            4'd0:    return 24'h000000;
            4'd1:    return 24'h0000AA;
            4'd2:    return 24'h00AA00;
            4'd3:    return 24'h00AAAA;
            4'd4:    return 24'hAA0000;
            4'd5:    return 24'hAA00AA;
            4'd6:    return 24'hAA5500;
            4'd7:    return 24'hAAAAAA;
            4'd8:    return 24'h555555;
            4'd9:    return 24'h5555FF;
            4'd10:   return 24'h55FF55;
            4'd11:   return 24'h55FFFF;
            4'd12:   return 24'hFF5555;
            4'd13:   return 24'hFF55FF;
            4'd14:   return 24'hFFFF55;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    function void write_reg(tcgr_pkg::cfg_idx_t idx, bit [15:0] val);
        case (idx)
            tcgr_pkg::CFG_ENABLE: enable = val[0];
            tcgr_pkg::CFG_WIDTH:  width  = val[11:0];
            tcgr_pkg::CFG_HEIGHT: height = val[11:0];
            tcgr_pkg::CFG_PITCH:  pitch  = val;
            tcgr_pkg::CFG_BPP:    bpp    = val[2:0];
            default: ;
        endcase
    endfunction

    // Note an accepted transaction; returns the number of lines it yields
    function int take_request(cell_req_t req);
        bit [23:0]   fg;
        bit [23:0]   bg;
        bit [31:0]   xoff;
        bit [31:0]   y;
        bit [7:0]    bits;
        glyph_line_t ln;
        if (req.action == tcgr_pkg::ACT_LOAD) begin
            font_rows[req.code][req.gline] = req.gbits;
            return 0;
        end
        // disabled console or cell off screen: nothing drawn
        if (!enable || req.col >= width / 12'd8 || req.row >= height / 12'd16)
            return 0;
        fg   = color_of(req.attr[3:0]);
        bg   = color_of(req.attr[7:4]);
        xoff = 32'(req.col) * 32'd8 * 32'(bpp);
        for (int ln_idx = 0; ln_idx < 16; ln_idx++) begin
            y       = 32'(req.row) * 32'd16 + 32'(ln_idx);
            ln.addr = FRAME_BASE + y * 32'(pitch) + xoff;
            bits    = font_rows[req.code][ln_idx];
            for (int p = 0; p < 8; p++)
                ln.pix[p] = bits[7 - p] ? fg : bg;
            ln.last = (ln_idx == 15);
            expected_lines.push_back(ln);
        end
        return 16;
    endfunction

    // Compare one accepted line write with the oldest prediction
    function void check_line(glyph_line_t got);
        glyph_line_t want;
        if (expected_lines.size() == 0) begin
            $error("unexpected line write, line_address %h", got.addr);
            mismatches++;
            return;
        end
        want = expected_lines.pop_front();
        lines_checked++;
        if (got.addr !== want.addr) begin
            $error("line_address: expected %h, actual %h", want.addr, got.addr);
            mismatches++;
        end
        for (int p = 0; p < 8; p++) begin
            if (got.pix[p] !== want.pix[p]) begin
                $error("pixel_%0d: expected %h, actual %h", p, want.pix[p], got.pix[p]);
                mismatches++;
            end
        end
        if (got.last !== want.last) begin
            $error("last_line: expected %b, actual %b", want.last, got.last);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_lines.size();
    endfunction
endclass

module text_cell_glyph_renderer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            cfg_we      = 1'b0;
    logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                            in_valid    = 1'b0;
    logic                            in_stall;
    logic                            action      = 1'b0;
    logic [7:0]                      char_code   = '0;
    logic [7:0]                      attribute   = '0;
    logic [8:0]                      cell_column = '0;
    logic [7:0]                      cell_row    = '0;
    logic [3:0]                      glyph_line  = '0;
    logic [7:0]                      glyph_bits  = '0;
    logic                            out_valid;
    logic                            out_stall   = 1'b0;
    logic [31:0]                     line_address;
    logic [23:0]                     pixel_0;
    logic [23:0]                     pixel_1;
    logic [23:0]                     pixel_2;
    logic [23:0]                     pixel_3;
    logic [23:0]                     pixel_4;
    logic [23:0]                     pixel_5;
    logic [23:0]                     pixel_6;
    logic [23:0]                     pixel_7;
    logic                            last_line;

    render_checker sb = new();

    int          tx_gap_pct   = 0;
    int          rx_stall_pct = 0;
    int unsigned cycle_count  = 0;
    int unsigned rows_loaded  = 0;
    int unsigned cells_drawn  = 0;
    int unsigned cells_dropped = 0;
    int unsigned settings_used = 0;

    bit       is_ready [256];
    bit [7:0] ready_glyphs[$];

    text_cell_glyph_renderer u_top (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lines outstanding",
                     cycle_count, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Output monitor
    always @(posedge clk)
    begin
        glyph_line_t got;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            got.addr   = line_address;
            got.pix[0] = pixel_0;
            got.pix[1] = pixel_1;
            got.pix[2] = pixel_2;
            got.pix[3] = pixel_3;
            got.pix[4] = pixel_4;
            got.pix[5] = pixel_5;
            got.pix[6] = pixel_6;
            got.pix[7] = pixel_7;
            got.last   = last_line;
            sb.check_line(got);
        end
    end

    // Present one transaction and wait for it to be taken
    task automatic send(cell_req_t req);
        int n;
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= req.action;
        char_code   <= req.code;
        attribute   <= req.attr;
        cell_column <= req.col;
        cell_row    <= req.row;
        glyph_line  <= req.gline;
        glyph_bits  <= req.gbits;
        do @(posedge clk); while (in_stall !== 1'b0);
        n = sb.take_request(req);
        if (req.action == tcgr_pkg::ACT_LOAD)
            rows_loaded++;
        else if (n > 0)
            cells_drawn++;
        else
            cells_dropped++;
    endtask

    function automatic cell_req_t random_fields();
        cell_req_t req;
        req.action = 1'($urandom);
        req.code   = 8'($urandom);
        req.attr   = 8'($urandom);
        req.col    = 9'($urandom);
        req.row    = 8'($urandom);
        req.gline  = 4'($urandom);
        req.gbits  = 8'($urandom);
        return req;
    endfunction

    // Row patterns lean toward empty and solid rows now and then
    function automatic bit [7:0] random_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic load_row(bit [7:0] code, bit [3:0] row, bit [7:0] bits);
        cell_req_t req;
        req        = random_fields();
        req.action = tcgr_pkg::ACT_LOAD;
        req.code   = code;
        req.gline  = row;
        req.gbits  = bits;
        send(req);
    endtask

    task automatic draw_at(bit [7:0] code, bit [8:0] col, bit [7:0] row, bit [7:0] attr);
        cell_req_t req;
        req        = random_fields();
        req.action = tcgr_pkg::ACT_DRAW;
        req.code   = code;
        req.col    = col;
        req.row    = row;
        req.attr   = attr;
        send(req);
    endtask

    function automatic void mark_ready(bit [7:0] code);
        if (!is_ready[code]) begin
            is_ready[code] = 1'b1;
            ready_glyphs.push_back(code);
        end
    endfunction

    // Full glyph: all sixteen rows, starting at a random row
    task automatic load_glyph(bit [7:0] code);
        bit [3:0] start;
        start = 4'($urandom);
        for (int i = 0; i < 16; i++)
            load_row(code, start + 4'(i), random_pattern());
        mark_ready(code);
    endtask

    function automatic bit [7:0] fresh_code();
        bit [7:0] code;
        do code = 8'($urandom); while (is_ready[code]);
        return code;
    endfunction

    // Mostly on-screen draws of loaded glyphs, some row reloads and stray cells
    task automatic mixed_traffic(int count);
        int       r;
        int       cols;
        int       rows;
        bit [7:0] code;
        for (int i = 0; i < count; i++) begin
            r    = $urandom_range(0, 99);
            code = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
            cols = sb.width / 8;
            rows = sb.height / 16;
            if (r < 20)
                load_row(code, 4'($urandom), random_pattern());
            else if (r < 35 || cols == 0 || rows == 0)
                draw_at(code, 9'($urandom), 8'($urandom), 8'($urandom));
            else if (r >= 92)
                draw_at(code, 9'(cols - 1), 8'(rows - 1), 8'($urandom));
            else
                draw_at(code, 9'($urandom_range(0, cols - 1)),
                        8'($urandom_range(0, rows - 1)), 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
        // margin so the block is back in idle before register writes
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(tcgr_pkg::cfg_idx_t idx, bit [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
    endtask

    // Registers change only with the block idle
    task automatic configure(bit en, bit [11:0] w, bit [11:0] h, bit [15:0] pitch,
                             bit [2:0] bpp);
        in_valid <= 1'b0;
        wait_drained();
        write_reg(tcgr_pkg::CFG_ENABLE, 16'(en));
        write_reg(tcgr_pkg::CFG_WIDTH, 16'(w));
        write_reg(tcgr_pkg::CFG_HEIGHT, 16'(h));
        write_reg(tcgr_pkg::CFG_PITCH, pitch);
        write_reg(tcgr_pkg::CFG_BPP, 16'(bpp));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        bit [7:0] pat;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: glyph 0 with edge-case rows, then draws at the screen limits
        tx_gap_pct   = 29;
        rx_stall_pct = 69;
        for (int i = 0; i < 16; i++) begin
            case (i)
                0:       pat = 8'h00;
                1:       pat = 8'hFF;
                2:       pat = 8'h80;
                3:       pat = 8'h01;
                4:       pat = 8'hAA;
                5:       pat = 8'h55;
                default: pat = 8'($urandom);
            endcase
            load_row(8'd0, 4'(i), pat);
        end
        mark_ready(8'd0);
        // console still disabled from reset
        draw_at(8'd0, 9'd0, 8'd0, 8'h0F);

        configure(1'b1, 12'd640, 12'd480, 16'd2560, 3'd4);
        draw_at(8'd0, 9'd0, 8'd0, 8'h0F);
        draw_at(8'd0, 9'd79, 8'd29, 8'hF0);
        draw_at(8'd0, 9'd80, 8'd0, 8'h1E);
        draw_at(8'd0, 9'd0, 8'd30, 8'h2D);
        draw_at(8'd0, 9'd40, 8'd15, 8'h00);
        draw_at(8'd0, 9'd1, 8'd1, 8'h9C);
        draw_at(8'd0, 9'd79, 8'd0, 8'h7B);
        draw_at(8'd0, 9'd0, 8'd29, 8'h34);
        draw_at(8'd0, 9'd511, 8'd255, 8'h6A);

        // Largest screen, widest step: addresses wrap past 2^32
        configure(1'b1, 12'd4095, 12'd4095, 16'hFFFF, 3'd7);
        load_glyph(8'd255);
        mixed_traffic(14);

        // Single-cell screen, no line or pixel step
        configure(1'b1, 12'd8, 12'd16, 16'd0, 3'd0);
        mixed_traffic(10);

        tx_gap_pct   = 69;
        rx_stall_pct = 29;
        configure(1'b0, 12'd4095, 12'd4095, 16'd2560, 3'd4);
        mixed_traffic(4);
        configure(1'b1, 12'd0, 12'd0, 16'd1, 3'd1);
        mixed_traffic(4);
        configure(1'b1, 12'($urandom_range(8, 4095)), 12'($urandom_range(16, 4095)),
                  16'($urandom), 3'($urandom_range(1, 4)));
        load_glyph(fresh_code());
        mixed_traffic(12);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        configure(1'b1, 12'd4095, 12'd4095, 16'($urandom), 3'($urandom_range(1, 4)));
        load_glyph(fresh_code());
        mixed_traffic(12);

        in_valid <= 1'b0;
        wait_drained();

        $display("Checked %0d lines from %0d drawn cells; %0d font rows loaded,",
                 sb.lines_checked, cells_drawn, rows_loaded);
        $display("%0d draws dropped (disabled or off screen), %0d register settings.",
                 cells_dropped, settings_used);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
